@@ rtl/acd_pkg.sv @@
// Shared types and constants for the archive chunk deframer.
// No dependencies; every other RTL file refers to this package by scoped names.
`default_nettype none

package acd_pkg;

    // Parser phase codes.
    localparam logic [2:0] PH_MAGIC  = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_INFO   = 3'd2;
    localparam logic [2:0] PH_STORED = 3'd3;
    localparam logic [2:0] PH_COMP   = 3'd4;
    localparam logic [2:0] PH_SKIP   = 3'd5;
    localparam logic [2:0] PH_HALT   = 3'd6;

    // Event codes reported with each result.
    localparam logic [2:0] EV_NONE          = 3'd0;
    localparam logic [2:0] EV_BAD_MAGIC     = 3'd1;
    localparam logic [2:0] EV_INFO_MISMATCH = 3'd2;
    localparam logic [2:0] EV_STORED_MISM   = 3'd3;
    localparam logic [2:0] EV_COMP_OK       = 3'd4;
    localparam logic [2:0] EV_COMP_MISM     = 3'd5;
    localparam logic [2:0] EV_BAD_METHOD    = 3'd6;
    localparam logic [2:0] EV_FINISHED      = 3'd7;

    // Configuration register indexes.
    localparam logic CFG_ARCHIVE_LENGTH = 1'b0;
    localparam logic CFG_INFO_LIMIT     = 1'b1;

    // Format constants.
    localparam logic [16:0] ADLER_MOD     = 17'd65521;
    localparam logic [15:0] ID_INFO       = 16'd1;
    localparam logic [15:0] ID_DATA       = 16'd17;
    localparam logic [15:0] OPT_STORED    = 16'd0;
    localparam logic [15:0] OPT_COMP      = 16'd1;
    localparam logic [31:0] INFO_MIN_SIZE = 32'd10;
    localparam logic [31:0] HEADER_BYTES  = 32'd16;
    localparam logic [15:0] LIMIT_RESET   = 16'd1024;

    // One result item.
    typedef struct packed {
        logic       pixel_valid;
        logic [7:0] pixel_byte;
        logic [2:0] event_res;
        logic       halted;
    } result_t;

    // Archive signature, one byte per position.
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'd137;
            3'd1:    val = 8'd54;
            3'd2:    val = 8'd80;
            3'd3:    val = 8'd75;
            3'd4:    val = 8'd13;
            3'd5:    val = 8'd10;
            3'd6:    val = 8'd26;
            3'd7:    val = 8'd10;
            default: val = 8'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

@@ rtl/archive_chunk_deframer.sv @@
// Archive chunk deframer top level: one byte in, one result out per request.
// A result is registered in a two-entry result buffer when its request is accepted.
// Throughput: one byte per cycle while the buffer has room, set by the combinational
// checksum and header update loop; the buffer absorbs results while the master stalls.
// Reset (rst_n low, asynchronous) clears parser state and the buffer; archive_length
// resets to 0 and info_chunk_limit to 1024.  Depends on acd_pkg and acd_parser.
`default_nettype none

module archive_chunk_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] restart
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [7:0] pixel_byte
    output logic      [4:0]  m_tuser,   // [0] pixel_valid, [3:1] event_res, [4] halted
    // Configuration writes
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [31:0]      archive_length_reg;
    logic [15:0]      info_limit_reg;
    logic             in_acc;
    logic             out_acc;
    acd_pkg::result_t res;
    acd_pkg::result_t buf_reg [2];
    acd_pkg::result_t head;
    logic [1:0]       count_reg;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            archive_length_reg <= 32'd0;
            info_limit_reg     <= acd_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                acd_pkg::CFG_ARCHIVE_LENGTH: archive_length_reg <= cfg_data;
                acd_pkg::CFG_INFO_LIMIT:     info_limit_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign in_acc  = s_tvalid & s_tready;
    assign out_acc = m_tvalid & m_tready;

    acd_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_en            (in_acc),
        .data_byte        (s_tdata),
        .restart          (s_tuser),
        .archive_length   (archive_length_reg),
        .info_chunk_limit (info_limit_reg),
        .result           (res)
    );

    // Result buffer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (out_acc)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (in_acc && !out_acc)
                count_reg <= count_reg + 2'd1;
            else if (!in_acc && out_acc)
                count_reg <= count_reg - 2'd1;
        end
    end

    // Result buffer storage.
    always_ff @(posedge clk)
    begin
        if (in_acc)
            buf_reg[wr_ptr_reg] <= res;
    end

    assign head     = buf_reg[rd_ptr_reg];
    assign s_tready = (count_reg != 2'd2);
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = head.pixel_byte;
    assign m_tuser  = {head.halted, head.event_res, head.pixel_valid};

`ifndef SYNTHESIS
    // The buffer never holds more than two results.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("result buffer count out of range");

    // The end-of-archive event always stops parsing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[3:1] == acd_pkg::EV_FINISHED) |-> m_tuser[4])
        else $error("finished event without halt");

    // A payload byte only comes with no event or a stored-chunk mismatch.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |->
        (m_tuser[3:1] == acd_pkg::EV_NONE || m_tuser[3:1] == acd_pkg::EV_STORED_MISM))
        else $error("payload byte with unexpected event");
`endif

endmodule

`default_nettype wire

@@ rtl/acd_adler.sv @@
// One-byte Adler-32 update with conditional subtraction of the modulus.
// Depends on acd_pkg for the modulus.
`default_nettype none

module acd_adler (
    input  wire logic [15:0] sum_low,
    input  wire logic [15:0] sum_high,
    input  wire logic [7:0]  data_byte,
    output logic      [15:0] low_upd,
    output logic      [15:0] high_upd
);

    logic [16:0] low_sum;
    logic [16:0] low_red;
    logic [16:0] high_sum;
    logic [16:0] high_red;

    // Low += byte, high += low, one fold each; sums stay below twice the modulus.
    always_comb
    begin
        low_sum = {1'b0, sum_low} + {9'd0, data_byte};
        if (low_sum >= acd_pkg::ADLER_MOD)
            low_red = low_sum - acd_pkg::ADLER_MOD;
        else
            low_red = low_sum;
        high_sum = {1'b0, sum_high} + low_red;
        if (high_sum >= acd_pkg::ADLER_MOD)
            high_red = high_sum - acd_pkg::ADLER_MOD;
        else
            high_red = high_sum;
    end

    assign low_upd  = low_red[15:0];
    assign high_upd = high_red[15:0];

endmodule

`default_nettype wire

@@ rtl/acd_parser.sv @@
// Chunk parser: signature check, header capture, per-chunk checksum and events.
// Depends on acd_pkg and acd_adler.
`default_nettype none

module acd_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_en,
    input  wire logic [7:0]      data_byte,
    input  wire logic            restart,
    input  wire logic [31:0]     archive_length,
    input  wire logic [15:0]     info_chunk_limit,
    output acd_pkg::result_t     result
);

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] off_reg, off_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] opt_reg, opt_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] exp_reg, exp_next;
    logic [15:0] low_reg, low_next;
    logic [15:0] high_reg, high_next;
    logic        fseen_reg, fseen_next;
    logic        snz_reg, snz_next;
    logic        inz_reg, inz_next;

    // Effective state after an optional restart.
    logic [2:0]  ph;
    logic [31:0] pos;
    logic [31:0] off;
    logic [15:0] low_eff;
    logic [15:0] high_eff;
    logic        fseen;
    logic        snz;
    logic        inz;

    logic [31:0] pos_inc;
    logic [15:0] low_upd;
    logic [15:0] high_upd;
    logic        hdr_sum_ok;
    logic        pay_sum_ok;
    logic        inz_upd;
    logic [2:0]  chunk_ph;
    logic [2:0]  ev;

    acd_adler u_adler (
        .sum_low   (low_eff),
        .sum_high  (high_eff),
        .data_byte (data_byte),
        .low_upd   (low_upd),
        .high_upd  (high_upd)
    );

    // Restart clears the archive state before this byte is handled.
    always_comb
    begin
        ph       = restart ? acd_pkg::PH_MAGIC : phase_reg;
        pos      = restart ? 32'd0 : pos_reg;
        off      = restart ? 32'd0 : off_reg;
        low_eff  = restart ? 16'd1 : low_reg;
        high_eff = restart ? 16'd0 : high_reg;
        fseen    = restart ? 1'b0 : fseen_reg;
        snz      = restart ? 1'b0 : snz_reg;
        inz      = restart ? 1'b0 : inz_reg;
    end

    assign pos_inc    = pos + 32'd1;
    assign hdr_sum_ok = (exp_reg == 32'd1);
    assign pay_sum_ok = (exp_reg == {high_upd, low_upd});
    assign inz_upd    = inz | ((ph == acd_pkg::PH_INFO) && (pos < 32'd4) && (data_byte != 8'd0));

    // Next state and result for one byte.
    always_comb
    begin
        phase_next = ph;
        pos_next   = pos;
        off_next   = off;
        id_next    = id_reg;
        opt_next   = opt_reg;
        size_next  = size_reg;
        exp_next   = exp_reg;
        low_next   = low_eff;
        high_next  = high_eff;
        fseen_next = fseen;
        snz_next   = snz;
        inz_next   = inz;
        chunk_ph   = acd_pkg::PH_SKIP;
        ev         = acd_pkg::EV_NONE;
        result     = '0;

        case (ph)
            acd_pkg::PH_MAGIC:
            begin
                if (data_byte != acd_pkg::magic_byte(pos[2:0]))
                begin
                    phase_next = acd_pkg::PH_HALT;
                    ev         = acd_pkg::EV_BAD_MAGIC;
                end
                else if (pos[2:0] == 3'd7)
                begin
                    phase_next = acd_pkg::PH_HEADER;
                    pos_next   = 32'd0;
                end
                else
                    pos_next = pos_inc;
            end

            acd_pkg::PH_HEADER:
            begin
                if ((pos[3:0] == 4'd0) && (off > archive_length))
                begin
                    phase_next = acd_pkg::PH_HALT;
                    ev         = acd_pkg::EV_FINISHED;
                end
                else
                begin
                    // Little-endian field capture by byte position.
                    case (pos[3:0])
                        4'd0:    id_next[7:0]    = data_byte;
                        4'd1:    id_next[15:8]   = data_byte;
                        4'd2:    opt_next[7:0]   = data_byte;
                        4'd3:    opt_next[15:8]  = data_byte;
                        4'd4:    size_next[7:0]  = data_byte;
                        4'd5:    size_next[15:8] = data_byte;
                        4'd6:    size_next[23:16] = data_byte;
                        4'd7:    size_next[31:24] = data_byte;
                        4'd8:    exp_next[7:0]   = data_byte;
                        4'd9:    exp_next[15:8]  = data_byte;
                        4'd10:   exp_next[23:16] = data_byte;
                        4'd11:   exp_next[31:24] = data_byte;
                        default: ;
                    endcase
                    pos_next = pos_inc;

                    // Last header byte: classify the chunk and open its payload.
                    if (pos[3:0] == 4'd15)
                    begin
                        pos_next  = 32'd0;
                        off_next  = off + acd_pkg::HEADER_BYTES + size_reg;
                        low_next  = 16'd1;
                        high_next = 16'd0;
                        inz_next  = 1'b0;
                        if ((id_reg == acd_pkg::ID_INFO) && (size_reg > acd_pkg::INFO_MIN_SIZE)
                            && (size_reg < {16'd0, info_chunk_limit}))
                            chunk_ph = acd_pkg::PH_INFO;
                        else if ((id_reg == acd_pkg::ID_DATA) && fseen && snz)
                        begin
                            if (opt_reg == acd_pkg::OPT_STORED)
                                chunk_ph = acd_pkg::PH_STORED;
                            else if (opt_reg == acd_pkg::OPT_COMP)
                                chunk_ph = acd_pkg::PH_COMP;
                            else
                            begin
                                chunk_ph   = acd_pkg::PH_SKIP;
                                ev         = acd_pkg::EV_BAD_METHOD;
                                fseen_next = 1'b0;
                            end
                        end
                        else
                            chunk_ph = acd_pkg::PH_SKIP;

                        phase_next = chunk_ph;
                        // An empty payload closes right here against the start value.
                        if (size_reg == 32'd0)
                        begin
                            phase_next = acd_pkg::PH_HEADER;
                            case (chunk_ph)
                                acd_pkg::PH_STORED:
                                begin
                                    if (!hdr_sum_ok)
                                    begin
                                        phase_next = acd_pkg::PH_HALT;
                                        ev         = acd_pkg::EV_STORED_MISM;
                                    end
                                end
                                acd_pkg::PH_COMP:
                                begin
                                    if (!hdr_sum_ok)
                                    begin
                                        phase_next = acd_pkg::PH_HALT;
                                        ev         = acd_pkg::EV_COMP_MISM;
                                    end
                                    else
                                        ev = acd_pkg::EV_COMP_OK;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end

            acd_pkg::PH_INFO, acd_pkg::PH_STORED, acd_pkg::PH_COMP, acd_pkg::PH_SKIP:
            begin
                low_next  = low_upd;
                high_next = high_upd;
                inz_next  = inz_upd;
                pos_next  = pos_inc;
                if (ph == acd_pkg::PH_STORED)
                begin
                    result.pixel_valid = 1'b1;
                    result.pixel_byte  = data_byte;
                end

                // Payload end: compare the running sum with the header checksum.
                if (pos_inc >= size_reg)
                begin
                    phase_next = acd_pkg::PH_HEADER;
                    pos_next   = 32'd0;
                    inz_next   = 1'b0;
                    case (ph)
                        acd_pkg::PH_INFO:
                        begin
                            if (!pay_sum_ok)
                            begin
                                phase_next = acd_pkg::PH_HALT;
                                ev         = acd_pkg::EV_INFO_MISMATCH;
                            end
                            else
                            begin
                                fseen_next = 1'b1;
                                snz_next   = inz_upd;
                            end
                        end
                        acd_pkg::PH_STORED:
                        begin
                            if (!pay_sum_ok)
                            begin
                                phase_next = acd_pkg::PH_HALT;
                                ev         = acd_pkg::EV_STORED_MISM;
                            end
                        end
                        acd_pkg::PH_COMP:
                        begin
                            if (!pay_sum_ok)
                            begin
                                phase_next = acd_pkg::PH_HALT;
                                ev         = acd_pkg::EV_COMP_MISM;
                            end
                            else
                                ev = acd_pkg::EV_COMP_OK;
                        end
                        default: ;
                    endcase
                end
            end

            acd_pkg::PH_HALT: ;

            default:
                phase_next = acd_pkg::PH_HALT;
        endcase

        result.event_res = ev;
        result.halted    = (phase_next == acd_pkg::PH_HALT);
    end

    // Parser state registers, advanced once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= acd_pkg::PH_MAGIC;
            pos_reg   <= 32'd0;
            off_reg   <= 32'd0;
            id_reg    <= 16'd0;
            opt_reg   <= 16'd0;
            size_reg  <= 32'd0;
            exp_reg   <= 32'd0;
            low_reg   <= 16'd1;
            high_reg  <= 16'd0;
            fseen_reg <= 1'b0;
            snz_reg   <= 1'b0;
            inz_reg   <= 1'b0;
        end
        else if (in_en)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            off_reg   <= off_next;
            id_reg    <= id_next;
            opt_reg   <= opt_next;
            size_reg  <= size_next;
            exp_reg   <= exp_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            fseen_reg <= fseen_next;
            snz_reg   <= snz_next;
            inz_reg   <= inz_next;
        end
    end

endmodule

`default_nettype wire
